>>> hw/rtl/gpl_pkg.sv
// Shared types and constants for the Goldbach prime pair lister.
package gpl_pkg;

  localparam int unsigned TARGET_W    = 9;
  localparam int unsigned SMALL_W     = 8;
  localparam int unsigned ADDR_W      = TARGET_W;
  localparam int unsigned MEM_DEPTH   = 1 << ADDR_W;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned SIEVE_D_W   = 5;
  localparam int unsigned SIEVE_M_W   = ADDR_W + 1;

  // Odd sieve divisors run from the first odd prime up to the largest odd d
  // with d * d below the bitmap depth.
  localparam logic [SIEVE_D_W-1:0] SIEVE_FIRST_D = 5'd3;
  localparam logic [SIEVE_D_W-1:0] SIEVE_LAST_D  = 5'd21;

  typedef logic [TARGET_W-1:0] target_t;
  typedef logic [SMALL_W-1:0]  small_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  typedef enum logic [2:0] {
    S_FILL,
    S_SIEVE,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FLUSH
  } state_t;

endpackage

>>> hw/rtl/goldbach_prime_pair_lister.sv
// Top level of the Goldbach prime pair lister: prime bitmap memory and scan sequencer.
//
// The block takes one word, a target number T, and returns one word per prime
// pair (p, q) with p <= q and p + q = T, in ascending order of p; the final
// word carries last_pair. When no pair exists (T below 4, an odd T whose
// T - 2 is not prime, or T above MAX_VALUE) a single word with pair_found
// cleared and last_pair set comes out. Primality comes from a 512 x 1 bitmap
// memory with one write port and two registered read ports. After reset the
// bitmap is built in place: a fill pass marks 2 and every odd number above 1,
// then a sieve pass clears the odd multiples of the odd divisors 3 to 21; no
// word is accepted until the bitmap is built. For each candidate p = 2 .. T/2
// the scan issues both bitmap reads in S_READ and inspects the registered data
// in S_CHECK. A target is accepted in S_IDLE; the scan ends in S_READ once p
// passes T/2 and goes on to S_FLUSH, and a target above MAX_VALUE goes from
// S_IDLE straight to S_FLUSH. One word is worked on at a time. Each pair is
// held back until the next pair turns up or the scan ends, so that the last
// mark can be set on the final one; a full output register that stays stalled
// holds the scan.
module goldbach_prime_pair_lister #(
  parameter int unsigned MAX_VALUE = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  gpl_pkg::target_t     in_target_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gpl_pkg::small_t      out_small_prime,
  output gpl_pkg::target_t     out_large_prime,
  output logic                 out_pair_found,
  output logic                 out_last_pair
);
  import gpl_pkg::*;

  localparam logic [10:0] MaxLim = 11'(MAX_VALUE);

  state_t state_r, state_nxt;

  // Bitmap memory and its ports.
  logic mem [MEM_DEPTH];
  logic  wr_en;
  addr_t wr_addr;
  logic  wr_data;
  logic  rd_en;
  addr_t rd_addr_a, rd_addr_b;
  logic  rd_a_r, rd_b_r;

  // Init counters.
  addr_t                fill_addr_r, fill_addr_nxt;
  logic [SIEVE_D_W-1:0] sieve_d_r, sieve_d_nxt;
  logic [SIEVE_M_W-1:0] sieve_m_r, sieve_m_nxt;
  logic [SIEVE_M_W-1:0] sieve_m_sum;
  logic [SIEVE_D_W-1:0] sieve_d_next_odd;
  logic [SIEVE_M_W-1:0] sieve_sq;

  // Scan state.
  target_t          t_r, t_nxt;
  target_t          p_r, p_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             hold_valid_r, hold_valid_nxt;
  small_t           hold_p_r, hold_p_nxt;
  target_t          hold_q_r, hold_q_nxt;

  // Output register.
  logic    out_valid_r, out_valid_nxt;
  small_t  out_small_r, out_small_nxt;
  target_t out_large_r, out_large_nxt;
  logic    out_found_r, out_found_nxt;
  logic    out_last_r, out_last_nxt;
  logic    out_free;

  assign out_free         = !out_valid_r || !out_stall;
  assign sieve_m_sum      = sieve_m_r + SIEVE_M_W'({sieve_d_r, 1'b0});
  assign sieve_d_next_odd = sieve_d_r + SIEVE_D_W'(2);
  assign sieve_sq         = SIEVE_M_W'(sieve_d_next_odd * sieve_d_next_odd);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      fill_addr_r  <= '0;
      sieve_d_r    <= SIEVE_FIRST_D;
      sieve_m_r    <= '0;
      count_r      <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_addr_r  <= fill_addr_nxt;
      sieve_d_r    <= sieve_d_nxt;
      sieve_m_r    <= sieve_m_nxt;
      count_r      <= count_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    p_r         <= p_nxt;
    hold_p_r    <= hold_p_nxt;
    hold_q_r    <= hold_q_nxt;
    out_small_r <= out_small_nxt;
    out_large_r <= out_large_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    fill_addr_nxt  = fill_addr_r;
    sieve_d_nxt    = sieve_d_r;
    sieve_m_nxt    = sieve_m_r;
    t_nxt          = t_r;
    p_nxt          = p_r;
    count_nxt      = count_r;
    hold_valid_nxt = hold_valid_r;
    hold_p_nxt     = hold_p_r;
    hold_q_nxt     = hold_q_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_small_nxt  = out_small_r;
    out_large_nxt  = out_large_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = fill_addr_r;
    wr_data        = 1'b0;
    rd_en          = 1'b0;
    rd_addr_a      = p_r;
    rd_addr_b      = t_r - p_r;
    in_stall       = 1'b1;

    unique case (state_r)
      S_FILL: begin
        // Mark 2 and every odd number above 1 as a candidate prime.
        wr_en         = 1'b1;
        wr_addr       = fill_addr_r;
        wr_data       = (fill_addr_r == ADDR_W'(2)) ||
                        (fill_addr_r[0] && (fill_addr_r != ADDR_W'(1)));
        fill_addr_nxt = fill_addr_r + ADDR_W'(1);
        if (fill_addr_r == '1) begin
          sieve_d_nxt = SIEVE_FIRST_D;
          sieve_m_nxt = SIEVE_M_W'(SIEVE_FIRST_D * SIEVE_FIRST_D);
          state_nxt   = S_SIEVE;
        end
      end
      S_SIEVE: begin
        // Clear the odd multiples d*d, d*d + 2d, ... of the current divisor.
        wr_en   = 1'b1;
        wr_addr = sieve_m_r[ADDR_W-1:0];
        wr_data = 1'b0;
        if (sieve_m_sum[SIEVE_M_W-1]) begin
          if (sieve_d_r == SIEVE_LAST_D) begin
            state_nxt = S_IDLE;
          end else begin
            sieve_d_nxt = sieve_d_next_odd;
            sieve_m_nxt = sieve_sq;
          end
        end else begin
          sieve_m_nxt = sieve_m_sum;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          t_nxt          = in_target_value;
          p_nxt          = TARGET_W'(2);
          count_nxt      = '0;
          hold_valid_nxt = 1'b0;
          // Drop targets beyond the limit straight to the no-pair word.
          if ({2'b00, in_target_value} > MaxLim) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (p_r > (t_r >> 1)) begin
          state_nxt = S_FLUSH;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rd_a_r && rd_b_r) begin
          if (count_r == CNT_W'(MAX_RESULTS)) begin
            state_nxt = S_FLUSH;
          end else if (!hold_valid_r || out_free) begin
            // Release the held pair, which is now known not to be the last.
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_small_nxt = hold_p_r;
              out_large_nxt = hold_q_r;
              out_found_nxt = 1'b1;
              out_last_nxt  = 1'b0;
            end
            hold_valid_nxt = 1'b1;
            hold_p_nxt     = p_r[SMALL_W-1:0];
            hold_q_nxt     = t_r - p_r;
            count_nxt      = count_r + CNT_W'(1);
            p_nxt          = p_r + TARGET_W'(1);
            state_nxt      = S_READ;
          end
        end else begin
          p_nxt     = p_r + TARGET_W'(1);
          state_nxt = S_READ;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_small_nxt  = hold_valid_r ? hold_p_r : '0;
          out_large_nxt  = hold_valid_r ? hold_q_r : '0;
          out_found_nxt  = hold_valid_r;
          out_last_nxt   = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_FILL;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_small_prime = out_small_r;
  assign out_large_prime = out_large_r;
  assign out_pair_found  = out_found_r;
  assign out_last_pair   = out_last_r;

  // A no-pair word is always the final word for its target.
  a_nopair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> out_last_r)
    else $error("no-pair word without last mark");

  // A pair that is not the last one belongs to the target still being scanned.
  a_pair_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r && !out_last_r) |->
      ((TARGET_W'(out_small_r) + out_large_r) == t_r))
    else $error("pair does not add up to the target");

  // Pairs are listed with the smaller prime first.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (TARGET_W'(out_small_r) <= out_large_r))
    else $error("pair out of order");

  // Nothing comes out while the bitmap is being built.
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL || state_r == S_SIEVE) |-> !out_valid_r)
    else $error("output word during bitmap build");

  // A word sitting stalled in the output register keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=>
      (out_valid_r && $stable(out_small_r) && $stable(out_large_r) &&
       $stable(out_found_r) && $stable(out_last_r)))
    else $error("stalled output word changed");

endmodule
